### hdl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// widest row / column fields over the supported parameter range
	localparam int ROW_W_MAX = 6;
	localparam int COL_W_MAX = 9;

	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

	localparam logic [3:0] FG_RESET = 4'hF;
	localparam logic [3:0] BG_RESET = 4'h0;

	localparam logic [7:0] SPACE_CODE   = 8'd32;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] INIT_COLOR   = 8'h0F;

	// work kinds handed from front to back
	localparam logic [1:0] KIND_NOP   = 2'd0;
	localparam logic [1:0] KIND_PUT   = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	typedef struct packed {
		logic [1:0]           kind;
		logic                 do_blank;   // blank row prow before anything else
		logic [ROW_W_MAX-1:0] prow;       // physical row of the cell or blanked row
		logic [COL_W_MAX-1:0] col;
		logic [7:0]           ch;
		logic [7:0]           color;
		logic [ROW_W_MAX-1:0] cur_row;    // cursor after the request
		logic [COL_W_MAX-1:0] cur_col;
	} cmd_t;

endpackage

### hdl/tcw_cmd_fifo.sv
// Two-entry command queue between the request front end and the cell engine.
module tcw_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output tcw_pkg::cmd_t head
);

	tcw_pkg::cmd_t                   entries_q [tcw_pkg::QUEUE_DEPTH];
	logic [tcw_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [tcw_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [tcw_pkg::QUEUE_AW:0]      count_q;

	assign full  = count_q == (tcw_pkg::QUEUE_AW+1)'(tcw_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("command queue underflow");

endmodule

### hdl/tcw_front.sv
// Request front end: color registers, cursor tracking and command classification.
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [tcw_pkg::S_USER_W-1:0]   s_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           init_busy,
	input  logic                           q_full,
	output logic                           q_push,
	output tcw_pkg::cmd_t                  q_data
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS + 1);
	localparam logic [RW:0]   ROWS_X    = (RW+1)'(ROWS);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COLS_FULL = CW'(COLUMNS);

	logic [3:0]    fg_q;
	logic [3:0]    bg_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] base_q;   // physical row that holds logical row 0

	logic [7:0]    ch;
	logic [4:0]    rd_row;
	logic [6:0]    rd_col;
	logic          accept;
	logic          is_nl;
	logic          need_nl;
	logic          row_last;
	logic          scroll;
	logic [RW-1:0] row_n;
	logic [CW-1:0] col_n;
	logic [RW-1:0] base_n;
	logic [CW-1:0] col_base;
	logic          rd_in_range;

	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] b);
		logic [RW:0] s;
		s = {1'b0, r} + {1'b0, b};
		if (s >= ROWS_X) begin
			s = s - ROWS_X;
		end
		return s[RW-1:0];
	endfunction

	assign ch     = s_tdata[7:0];
	assign rd_row = s_tdata[12:8];
	assign rd_col = s_tdata[19:13];

	assign s_tready  = !q_full && !init_busy;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign q_push    = accept;

	assign is_nl    = ch == tcw_pkg::NEWLINE_CODE;
	assign need_nl  = is_nl || (col_q >= COLS_FULL);
	assign row_last = row_q == LAST_ROW;
	assign scroll   = need_nl && row_last;
	assign rd_in_range = (32'(rd_row) < ROWS) && (32'(rd_col) < COLUMNS);

	always_comb begin
		row_n    = row_q;
		col_n    = col_q;
		base_n   = base_q;
		col_base = need_nl ? '0 : col_q;
		q_data   = '0;
		q_data.color   = {bg_q, fg_q};
		q_data.ch      = ch;
		case (s_tuser)
			tcw_pkg::REQ_PUT: begin
				if (need_nl && !row_last) begin
					row_n = row_q + RW'(1);
				end
				if (scroll) begin
					base_n = (base_q == LAST_ROW) ? '0 : base_q + RW'(1);
				end
				col_n = is_nl ? '0 : col_base + CW'(1);
				q_data.kind     = is_nl ? tcw_pkg::KIND_NOP : tcw_pkg::KIND_PUT;
				q_data.do_blank = scroll;
				// after a scroll the new last row sits where row 0 used to be
				q_data.prow     = tcw_pkg::ROW_W_MAX'(phys_row(row_n, base_n));
				q_data.col      = tcw_pkg::COL_W_MAX'(col_base);
			end
			tcw_pkg::REQ_CLEAR: begin
				q_data.kind = tcw_pkg::KIND_CLEAR;
			end
			tcw_pkg::REQ_READ: begin
				if (rd_in_range) begin
					q_data.kind = tcw_pkg::KIND_READ;
					q_data.prow = tcw_pkg::ROW_W_MAX'(phys_row(RW'(rd_row), base_q));
					q_data.col  = tcw_pkg::COL_W_MAX'(rd_col);
				end else begin
					q_data.kind = tcw_pkg::KIND_NOP;
				end
			end
			default: begin
				q_data.kind = tcw_pkg::KIND_NOP;
			end
		endcase
		q_data.cur_row = tcw_pkg::ROW_W_MAX'(row_n);
		q_data.cur_col = tcw_pkg::COL_W_MAX'(col_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q   <= tcw_pkg::FG_RESET;
			bg_q   <= tcw_pkg::BG_RESET;
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
		end else begin
			if (cfg_valid && cfg_index == tcw_pkg::CFG_FOREGROUND) begin
				fg_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == tcw_pkg::CFG_BACKGROUND) begin
				bg_q <= cfg_data;
			end
			if (accept) begin
				row_q  <= row_n;
				col_q  <= col_n;
				base_q <= base_n;
			end
		end
	end

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < ROWS) && (32'(base_q) < ROWS) && (32'(col_q) <= COLUMNS))
		else $error("cursor or row base out of range");

endmodule

### hdl/tcw_back.sv
// Cell engine: screen memory, row blanking, clear and reset sweeps, result register.
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  tcw_pkg::cmd_t                q_head,
	output logic                         q_pop,
	output logic                         init_busy,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tcw_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_BLANK  = 3'd2;
	localparam logic [2:0] ST_CELL   = 3'd3;
	localparam logic [2:0] ST_RDWAIT = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;

	logic [15:0]   mem [CELLS];
	logic [2:0]    state_q;
	tcw_pkg::cmd_t cmd_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] cnt_q;
	logic [15:0]   rd_data_q;
	logic          out_valid_q;
	logic [tcw_pkg::M_DATA_W-1:0] out_data_q;

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          emit;
	tcw_pkg::cmd_t res_cmd;
	logic [15:0]   res_cell;
	logic          blank_end;
	logic          sweep_end;
	logic [AW-1:0] head_addr;

	assign init_busy = state_q == ST_INIT;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && (!out_valid_q || m_tready);
	assign blank_end = cnt_q == AW'(COLUMNS - 1);
	assign sweep_end = cnt_q == AW'(CELLS - 1);
	assign head_addr = AW'(32'(q_head.prow) * COLUMNS
		+ (q_head.do_blank ? 32'd0 : 32'(q_head.col)));

	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		wr_addr = cnt_q;
		wr_data = {cmd_q.color, tcw_pkg::SPACE_CODE};
		emit    = 1'b0;
		res_cmd = cmd_q;
		case (state_q)
			ST_INIT: begin
				mem_we  = 1'b1;
				wr_data = {tcw_pkg::INIT_COLOR, tcw_pkg::SPACE_CODE};
			end
			ST_IDLE: begin
				res_cmd = q_head;
				emit    = q_pop && q_head.kind == tcw_pkg::KIND_NOP && !q_head.do_blank;
			end
			ST_BLANK: begin
				mem_we  = 1'b1;
				wr_addr = addr_q + cnt_q;
				emit    = blank_end && cmd_q.kind != tcw_pkg::KIND_PUT;
			end
			ST_CELL: begin
				if (cmd_q.kind == tcw_pkg::KIND_PUT) begin
					mem_we  = 1'b1;
					wr_addr = addr_q;
					wr_data = {cmd_q.color, cmd_q.ch};
					emit    = 1'b1;
				end else begin
					mem_re = 1'b1;
				end
			end
			ST_RDWAIT: begin
				emit = 1'b1;
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				emit   = sweep_end;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		res_cell = (state_q == ST_RDWAIT) ? rd_data_q : 16'd0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_q <= mem[addr_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q  <= q_head;
			addr_q <= head_addr;
		end
		if (emit) begin
			out_data_q <= {4'd0, res_cmd.cur_col[6:0], res_cmd.cur_row[4:0],
				res_cell[15:8], res_cell[7:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					cnt_q <= sweep_end ? '0 : cnt_q + AW'(1);
					if (sweep_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_pop) begin
						if (q_head.do_blank) begin
							state_q <= ST_BLANK;
						end else begin
							case (q_head.kind)
								tcw_pkg::KIND_PUT:   state_q <= ST_CELL;
								tcw_pkg::KIND_READ:  state_q <= ST_CELL;
								tcw_pkg::KIND_CLEAR: state_q <= ST_CLEAR;
								default:             state_q <= ST_IDLE;
							endcase
						end
					end
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + AW'(1);
					if (blank_end) begin
						state_q <= (cmd_q.kind == tcw_pkg::KIND_PUT) ? ST_CELL : ST_IDLE;
					end
				end
				ST_CELL: begin
					state_q <= (cmd_q.kind == tcw_pkg::KIND_PUT) ? ST_IDLE : ST_RDWAIT;
				end
				ST_RDWAIT: begin
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					if (sweep_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_valid_q || m_tready)
		else $error("result register overwritten before transfer");

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !q_pop)
		else $error("command taken during reset sweep");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_CLEAR || state_q == ST_BLANK)
			|-> 32'(cnt_q) < CELLS)
		else $error("sweep counter out of range");

endmodule

### hdl/text_console_writer.sv
// Text console writer top level: front end, command queue and cell engine.
// Character-cell screen of ROWS x COLUMNS cells (character low byte, color high byte) with a
// cursor. Requests enter on s_* and each one returns exactly one result on m_*; the front end
// tracks the cursor and takes a request per cycle, while the queue is not full and the reset
// fill is done, into a two-entry queue; the cell engine behind it does the memory work over
// one write port. In the cell engine a put writes its cell, a read of an on-screen cell reads
// it through a read register, and a newline without scroll, a read off the screen or an
// unused request type needs no memory access; a newline or wrap on the last row first blanks
// the new last row (rows are rotated, not copied), and a clear writes all ROWS*COLUMNS cells.
// After reset the engine fills the screen with white-on-black spaces, with s_tready low;
// configuration writes are taken at any time and apply to requests accepted afterwards.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] char_code, [12:8] cell_row, [19:13] cell_col, [23:20] zero
	input  logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
	// [1:0] req_type
	input  logic [tcw_pkg::S_USER_W-1:0]   s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] cell_char, [15:8] cell_color, [20:16] cursor_row, [27:21] cursor_col, [31:28] zero
	output logic [tcw_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic          init_busy;
	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_valid;
	tcw_pkg::cmd_t q_data;
	tcw_pkg::cmd_t q_head;

	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.init_busy (init_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	tcw_cmd_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for the text console writer: requests checked against a screen and cursor model.
module testbench;
	import tcw_pkg::*;

	localparam int COLS   = COLUMNS_DEF;
	localparam int ROWS_N = ROWS_DEF;
	localparam int CELLS  = COLS * ROWS_N;

	localparam logic [1:0]           REQ_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int SEGMENTS     = 8;
	localparam int SEG_ITEMS    = 130;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] ch;
		logic [7:0] color;
		logic [4:0] row;
		logic [6:0] col;
	} cell_result_t;

	typedef struct packed {
		logic [1:0]   req;
		logic [7:0]   ch;
		logic [4:0]   row;
		logic [6:0]   col;
		logic [7:0]   reps;
		logic         typed;
		cell_result_t want;
	} script_row_t;

	localparam cell_result_t NO_WANT = '0;

	// runs with reset colors: white on black
	localparam script_row_t SCRIPT [0:23] = '{
		'{REQ_READ,   8'h00,        5'd0,  7'd0,   8'd1,  1'b1, '{SPACE_CODE, INIT_COLOR, 5'd0, 7'd0}},
		'{REQ_READ,   8'hFF,        5'd24, 7'd79,  8'd1,  1'b1, '{SPACE_CODE, INIT_COLOR, 5'd0, 7'd0}},
		'{REQ_READ,   8'h00,        5'd25, 7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
		'{REQ_READ,   8'h00,        5'd31, 7'd127, 8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
		'{REQ_READ,   8'h00,        5'd0,  7'd80,  8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
		'{REQ_UNUSED, 8'hFF,        5'd31, 7'd127, 8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
		'{REQ_PUT,    8'h41,        5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
		'{REQ_PUT,    8'hFF,        5'd31, 7'd127, 8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
		'{REQ_PUT,    8'h00,        5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd3}},
		'{REQ_READ,   8'h00,        5'd0,  7'd1,   8'd1,  1'b1, '{8'hFF, INIT_COLOR, 5'd0, 7'd3}},
		'{REQ_PUT,    NEWLINE_CODE, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
		'{REQ_PUT,    8'h78,        5'd0,  7'd0,   8'd80, 1'b0, NO_WANT},
		'{REQ_READ,   8'h00,        5'd1,  7'd79,  8'd1,  1'b0, NO_WANT},
		// full row: wrap first
		'{REQ_PUT,    8'h79,        5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd2, 7'd1}},
		'{REQ_PUT,    NEWLINE_CODE, 5'd0,  7'd0,   8'd22, 1'b0, NO_WANT},
		'{REQ_PUT,    8'h7A,        5'd0,  7'd0,   8'd80, 1'b0, NO_WANT},
		// wrap on the last row scrolls
		'{REQ_PUT,    8'h77,        5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd24, 7'd1}},
		'{REQ_READ,   8'h00,        5'd23, 7'd0,   8'd1,  1'b0, NO_WANT},
		'{REQ_READ,   8'h00,        5'd24, 7'd1,   8'd1,  1'b0, NO_WANT},
		'{REQ_PUT,    NEWLINE_CODE, 5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd24, 7'd0}},
		'{REQ_READ,   8'h00,        5'd0,  7'd0,   8'd1,  1'b0, NO_WANT},
		'{REQ_CLEAR,  8'h00,        5'd0,  7'd0,   8'd1,  1'b1, '{8'h00, 8'h00, 5'd24, 7'd0}},
		'{REQ_READ,   8'h00,        5'd12, 7'd40,  8'd1,  1'b1, '{SPACE_CODE, INIT_COLOR, 5'd24, 7'd0}},
		'{REQ_PUT,    8'h7F,        5'd0,  7'd0,   8'd1,  1'b0, NO_WANT}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [S_USER_W-1:0]   s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// screen and cursor model
	logic [15:0] screen_model [0:CELLS-1];
	logic [4:0]  cursor_row_m;
	logic [6:0]  cursor_col_m;
	logic [3:0]  fg_m;
	logic [3:0]  bg_m;

	cell_result_t awaited_results [$];
	int           mismatch_count = 0;
	int           send_idle = 0;
	int           recv_stall = 0;
	logic         hold_pending = 1'b0;

	text_console_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic blank_model_row(input int r);
		for (int c = 0; c < COLS; c++)
			screen_model[r * COLS + c] = {bg_m, fg_m, SPACE_CODE};
	endtask

	task automatic model_newline();
		cursor_col_m = '0;
		if (cursor_row_m < ROWS_N - 1) begin
			cursor_row_m++;
		end else begin
			for (int i = COLS; i < CELLS; i++)
				screen_model[i - COLS] = screen_model[i];
			blank_model_row(ROWS_N - 1);
		end
	endtask

	task automatic console_predict(input logic [1:0] req, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc, output cell_result_t res);
		res = '0;
		case (req)
			REQ_PUT: begin
				if (ch == NEWLINE_CODE) begin
					model_newline();
				end else begin
					if (cursor_col_m >= COLS)
						model_newline();
					screen_model[cursor_row_m * COLS + cursor_col_m] = {bg_m, fg_m, ch};
					cursor_col_m++;
				end
			end
			REQ_CLEAR: begin
				for (int r = 0; r < ROWS_N; r++)
					blank_model_row(r);
			end
			REQ_READ: begin
				if (rr < ROWS_N && rc < COLS) begin
					res.ch    = screen_model[rr * COLS + rc][7:0];
					res.color = screen_model[rr * COLS + rc][15:8];
				end
			end
			default: ;
		endcase
		res.row = cursor_row_m;
		res.col = cursor_col_m;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (idx == CFG_FOREGROUND)
			fg_m = value;
		else if (idx == CFG_BACKGROUND)
			bg_m = value;
		@(posedge clk);
	endtask

	task automatic offer_request(input logic [1:0] req, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc, input logic typed,
			input cell_result_t want);
		cell_result_t predicted;
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tuser  <= req;
		s_tdata  <= {4'b0000, rc, rr, ch};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		console_predict(req, ch, rr, rc, predicted);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	// mostly text and newlines so the cursor wraps and the screen scrolls
	task automatic random_request(output logic [1:0] req, output logic [7:0] ch,
			output logic [4:0] rr, output logic [6:0] rc);
		int pick;
		pick = $urandom_range(0, 999);
		ch   = 8'($urandom_range(0, 255));
		rr   = 5'($urandom_range(0, 31));
		rc   = 7'($urandom_range(0, 127));
		if (pick < 600) begin
			req = REQ_PUT;
			if (pick >= 60)
				ch = 8'($urandom_range(32, 126));
		end else if (pick < 700) begin
			req = REQ_PUT;
			ch  = NEWLINE_CODE;
		end else if (pick < 880) begin
			req = REQ_READ;
			if (pick < 790 && cursor_col_m > 0) begin
				rr = cursor_row_m;
				rc = cursor_col_m - 7'd1;
			end else begin
				rr = 5'($urandom_range(0, ROWS_N - 1));
				rc = 7'($urandom_range(0, COLS - 1));
			end
		end else if (pick < 920) begin
			req = REQ_READ;
		end else if (pick < 960) begin
			req = REQ_UNUSED;
		end else if (pick < 993) begin
			req = REQ_PUT;
		end else begin
			req = REQ_CLEAR;
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				$error("result transfer with nothing expected: m_tdata %h", m_tdata);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("cell_char", int'(want.ch), int'(m_tdata[7:0]));
				check_field("cell_color", int'(want.color), int'(m_tdata[15:8]));
				check_field("cursor_row", int'(want.row), int'(m_tdata[20:16]));
				check_field("cursor_col", int'(want.col), int'(m_tdata[27:21]));
			end
		end
	end

	// receiver: random stalls, plus one long hold to back the block up
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [1:0] req;
		logic [7:0] ch;
		logic [4:0] rr;
		logic [6:0] rc;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = {INIT_COLOR, SPACE_CODE};
		cursor_row_m = '0;
		cursor_col_m = '0;
		fg_m = FG_RESET;
		bg_m = BG_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			// every request answers, so an empty queue means idle
			while (awaited_results.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
			case (seg)
				0: begin
					write_register(CFG_FOREGROUND, FG_RESET);
					write_register(CFG_BACKGROUND, BG_RESET);
				end
				1: begin
					write_register(CFG_FOREGROUND, 4'h0);
					write_register(CFG_BACKGROUND, 4'h0);
					write_register(CFG_SPARE_LO, 4'($urandom_range(0, 15)));
					write_register(CFG_SPARE_HI, 4'($urandom_range(0, 15)));
				end
				2: begin
					write_register(CFG_FOREGROUND, 4'hF);
					write_register(CFG_BACKGROUND, 4'hF);
				end
				3: begin
					write_register(CFG_FOREGROUND, 4'h0);
					write_register(CFG_BACKGROUND, 4'hF);
				end
				default: begin
					write_register(CFG_FOREGROUND, 4'($urandom_range(0, 15)));
					write_register(CFG_BACKGROUND, 4'($urandom_range(0, 15)));
				end
			endcase
			case (seg % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 78; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 78; end
				default: begin send_idle = 19; recv_stall = 19; end
			endcase
			if (seg == 0) begin
				foreach (SCRIPT[k])
					repeat (SCRIPT[k].reps)
						offer_request(SCRIPT[k].req, SCRIPT[k].ch, SCRIPT[k].row,
							SCRIPT[k].col, SCRIPT[k].typed, SCRIPT[k].want);
			end
			if (seg == 4)
				hold_pending = 1'b1;
			repeat (SEG_ITEMS) begin
				random_request(req, ch, rr, rc);
				offer_request(req, ch, rr, rc, 1'b0, NO_WANT);
			end
			s_tvalid <= 1'b0;
		end

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
hdl/tcw_pkg.sv
hdl/tcw_cmd_fifo.sv
hdl/tcw_front.sv
hdl/tcw_back.sv
hdl/text_console_writer.sv
sim/testbench.sv
